>>> rtl/core/sgdmf_pkg.sv
package sgdmf_pkg;

  localparam int NUM_FACTORS_DEF = 32;
  localparam int NUM_USERS_DEF   = 4096;
  localparam int NUM_ITEMS_DEF   = 4096;
  localparam int FRAC_BITS_DEF   = 24;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_TRAIN = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE    = 2'd0,
    REG_SHRINK_USER   = 2'd1,
    REG_SHRINK_ITEM   = 2'd2,
    REG_GLOBAL_OFFSET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [11:0]        user_index;
    logic [11:0]        item_index;
    logic signed [31:0] rating;
    logic               table_select;
    logic [4:0]         factor_index;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic signed [31:0] read_value;
  } out_item_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [71:0] maxv;
    logic signed [71:0] minv;
    maxv = 72'sd2147483647;
    minv = -72'sd2147483648;
    if (x > maxv) return 32'sh7fffffff;
    else if (x < minv) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

>>> rtl/core/sgdmf_ram.sv
module sgdmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sgd_matrix_factor_update.sv
// Channel | Direction | Handshake            | Payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_ready    | in_item (in_item_t)
// out     | out       | out_valid/out_ready  | out_item (out_item_t)
// Train makes two passes over the factors: one pass reads both rows and
// accumulates the dot product, a second pass rereads and writes back. Each
// factor RAM has a single read port, hence the two passes. Evaluate does only
// the dot-product pass; write and read access a single element.
// rst clears control state and the configuration registers; factor RAMs hold no reset value.
// A new item is taken once the previous result has left the output register.
module sgd_matrix_factor_update
  import sgdmf_pkg::*;
#(
  parameter int NUM_FACTORS = NUM_FACTORS_DEF,
  parameter int NUM_USERS   = NUM_USERS_DEF,
  parameter int NUM_ITEMS   = NUM_ITEMS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  localparam int FW  = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
  localparam int FCW = $clog2(NUM_FACTORS + 1);
  localparam int UW  = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int IW  = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int UDEPTH = NUM_USERS * NUM_FACTORS;
  localparam int IDEPTH = NUM_ITEMS * NUM_FACTORS;
  localparam int UAW = $clog2(UDEPTH);
  localparam int IAW = $clog2(IDEPTH);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DOT   = 10'b0000000010,
    S_DRAIN = 10'b0000000100,
    S_RES   = 10'b0000001000,
    S_SCALE = 10'b0000010000,
    S_SAT   = 10'b0000100000,
    S_UPD   = 10'b0001000000,
    S_ACC   = 10'b0010000000,
    S_READ  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [23:0]        learn_rate;
  logic [24:0]        shrink_user;
  logic [24:0]        shrink_item;
  logic signed [31:0] global_offset;

  in_item_t           cur;
  logic [FCW-1:0]     rd_cnt;
  logic [FCW-1:0]     wr_cnt;
  logic               rd_vld;
  logic [FW-1:0]      rd_f;
  logic signed [71:0] dot;
  logic signed [63:0] prod;
  logic               prod_vld;
  logic signed [31:0] res;
  logic signed [63:0] scaled_full;
  logic signed [31:0] scaled;

  // Update pipeline registers
  logic signed [63:0] pu_a, pu_b, pi_a, pi_b;
  logic               p_vld;
  logic [FW-1:0]      p_f;

  logic               u_we, i_we;
  logic [UAW-1:0]     u_waddr, u_raddr;
  logic [IAW-1:0]     i_waddr, i_raddr;
  logic [31:0]        u_wdata, i_wdata, u_rdata, i_rdata;

  logic [UW-1:0] urow;
  logic [IW-1:0] irow;
  logic          fidx_ok;

  assign urow = UW'(cur.user_index % NUM_USERS);
  assign irow = IW'(cur.item_index % NUM_ITEMS);
  assign fidx_ok = (32'(cur.factor_index) < NUM_FACTORS);

  sgdmf_ram #(.WIDTH(32), .DEPTH(UDEPTH)) u_user_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  sgdmf_ram #(.WIDTH(32), .DEPTH(IDEPTH)) u_item_ram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !out_valid;

  // Read addresses: element pass, or the accessed element
  logic [FW-1:0] rf;
  assign rf = (state == S_IDLE || state == S_READ || state == S_ACC)
              ? FW'(cur.factor_index) : FW'(rd_cnt);
  assign u_raddr = UAW'(urow * NUM_FACTORS + rf);
  assign i_raddr = IAW'(irow * NUM_FACTORS + rf);

  // Write-back of updated elements, or single element write
  logic signed [31:0] new_u, new_i;
  assign new_u = sat32(72'(pu_a >>> FRAC_BITS) + 72'(pu_b >>> FRAC_BITS));
  assign new_i = sat32(72'(pi_a >>> FRAC_BITS) + 72'(pi_b >>> FRAC_BITS));

  always_comb begin
    u_we = 1'b0;
    i_we = 1'b0;
    u_waddr = UAW'(urow * NUM_FACTORS + p_f);
    i_waddr = IAW'(irow * NUM_FACTORS + p_f);
    u_wdata = new_u;
    i_wdata = new_i;
    if (state == S_UPD && p_vld) begin
      u_we = 1'b1;
      i_we = 1'b1;
    end else if (state == S_ACC && cur.command == CMD_WRITE && fidx_ok) begin
      u_waddr = UAW'(urow * NUM_FACTORS + FW'(cur.factor_index));
      i_waddr = IAW'(irow * NUM_FACTORS + FW'(cur.factor_index));
      u_wdata = cur.write_value;
      i_wdata = cur.write_value;
      u_we = !cur.table_select;
      i_we = cur.table_select;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate    <= 24'd117440;
      shrink_user   <= 25'd16776981;
      shrink_item   <= 25'd16776981;
      global_offset <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LEARN_RATE:    learn_rate <= cfg_data[23:0];
        REG_SHRINK_USER:   shrink_user <= cfg_data[24:0];
        REG_SHRINK_ITEM:   shrink_item <= cfg_data[24:0];
        REG_GLOBAL_OFFSET: global_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      prod_vld  <= 1'b0;
      p_vld     <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur    <= in_item;
            rd_cnt <= '0;
            wr_cnt <= '0;
            dot    <= '0;
            rd_vld <= 1'b0;
            prod_vld <= 1'b0;
            p_vld  <= 1'b0;
            if (in_item.command == CMD_TRAIN || in_item.command == CMD_EVAL)
              state <= S_DOT;
            else
              state <= S_ACC;
          end
        end
        // Stream rows: address, data, product, accumulate
        S_DOT: begin
          rd_vld <= 1'b1;
          rd_f   <= FW'(rd_cnt);
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == FCW'(NUM_FACTORS - 1)) state <= S_DRAIN;
          prod     <= $signed(u_rdata) * $signed(i_rdata);
          prod_vld <= rd_vld;
          if (prod_vld) dot <= dot + 72'(prod >>> FRAC_BITS);
        end
        S_DRAIN: begin
          rd_vld   <= 1'b0;
          prod     <= $signed(u_rdata) * $signed(i_rdata);
          prod_vld <= rd_vld;
          if (prod_vld) dot <= dot + 72'(prod >>> FRAC_BITS);
          if (!rd_vld && !prod_vld) state <= S_RES;
        end
        S_RES: begin
          res <= sat32(72'(cur.rating) - dot - 72'(global_offset));
          state <= S_SCALE;
        end
        S_SCALE: begin
          scaled_full <= res * $signed({1'b0, learn_rate});
          if (cur.command == CMD_TRAIN) state <= S_SAT;
          else begin
            out_item.residual   <= res;
            out_item.read_value <= '0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SAT: begin
          scaled <= sat32(72'(scaled_full >>> FRAC_BITS));
          rd_cnt <= '0;
          rd_vld <= 1'b0;
          state  <= S_UPD;
        end
        // Reread each element, register the products, then write back
        S_UPD: begin
          if (rd_cnt != FCW'(NUM_FACTORS)) rd_cnt <= rd_cnt + 1'b1;
          rd_vld <= (rd_cnt != FCW'(NUM_FACTORS));
          rd_f   <= FW'(rd_cnt);
          p_vld  <= rd_vld;
          p_f    <= rd_f;
          pu_a <= $signed({1'b0, shrink_user}) * $signed(u_rdata);
          pu_b <= scaled * $signed(i_rdata);
          pi_a <= $signed({1'b0, shrink_item}) * $signed(i_rdata);
          pi_b <= scaled * $signed(u_rdata);
          if (p_vld) begin
            wr_cnt <= wr_cnt + 1'b1;
            if (wr_cnt == FCW'(NUM_FACTORS - 1)) begin
              out_item.residual   <= res;
              out_item.read_value <= '0;
              out_valid <= 1'b1;
              p_vld  <= 1'b0;
              rd_vld <= 1'b0;
              state  <= S_IDLE;
            end
          end
        end
        S_ACC: begin
          if (cur.command == CMD_WRITE) begin
            out_item  <= '0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          out_item.residual <= '0;
          out_item.read_value <= !fidx_ok ? 32'sd0 :
                                 (cur.table_select ? i_rdata : u_rdata);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No new item while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("item accepted with result pending");
  // Write-back only in the update pass
  a_upd_we: assert property (@(posedge clk) disable iff (rst)
    (u_we && i_we) |-> (state == S_UPD)) else $error("dual write outside update");
  // Results only come from working states
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) != S_IDLE) else $error("spurious result");

endmodule
